### hdl/upsample_grad_block_sum_macros.svh
// Assertion macros shared by the block sum design.
`ifndef UPSAMPLE_GRAD_BLOCK_SUM_MACROS_SVH
`define UPSAMPLE_GRAD_BLOCK_SUM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UGBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upsample_grad_block_sum: assertion failed");

// Next-cycle implication, checked outside reset.
`define UGBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upsample_grad_block_sum: assertion failed");

`endif

### hdl/upsgb_pkg.sv
// Package with the constants and types of the upsampling gradient block sum.
package upsgb_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_SCALE_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SUM_BITS      = 24;
  localparam int IDX_BITS      = 12;
  localparam int ROW_LIMIT     = 4096;
  localparam int ROW_BITS      = 12;
  localparam int SCALE_BITS    = 5;
  localparam int DIM_BITS      = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int DIM_RESET     = 4096;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_HEIGHT = 2'd2;

  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [IDX_BITS-1:0] idx_t;

endpackage

### hdl/upsgb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module upsgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### hdl/upsample_grad_block_sum.sv
// Top level: streaming block sum for the backward pass of nearest-neighbour upsampling.
// Path: an accepted sample waits in the second stage register; a sum that ends a block is
// then loaded into the output register. Throughput: one sample per cycle, set by one
// read-add-write of the column sum RAM, unless a finished sum waits for the output register.
// Reset: rst_n is synchronous and active low; it clears the frame position, the valids and
// the registers (scale 1, height 4096, width 4096 or MAX_WIDTH if less); column sums stay.
`include "upsample_grad_block_sum_macros.svh"

module upsample_grad_block_sum import upsgb_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_SCALE   = MAX_SCALE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write channel.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_wdata,
  // Sample input channel.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  in_grad_sample,
  // Block sum output channel.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SUM_BITS-1:0]     out_block_sum,
  output logic [IDX_BITS-1:0]     out_in_col,
  output logic [IDX_BITS-1:0]     out_in_row,
  output logic                    out_frame_end
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int PH_BITS  = $clog2(MAX_SCALE);
  localparam int EXT_BITS = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;
  localparam int COL_RST  = ((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET) - 1;
  localparam int ROW_RST  = ((DIM_RESET > ROW_LIMIT) ? ROW_LIMIT : DIM_RESET) - 1;

  // The configuration registers are kept as the last position of a block or a
  // plane, already clamped, so the position logic needs only equality tests.
  logic [PH_BITS-1:0]  scale_last_r, scale_last_nxt;
  logic [COL_BITS-1:0] col_last_r, col_last_nxt;
  logic [ROW_BITS-1:0] row_last_r, row_last_nxt;

  // Frame position.
  logic [COL_BITS-1:0] out_col_r, out_col_nxt;
  logic [ROW_BITS-1:0] out_row_r, out_row_nxt;
  logic [PH_BITS-1:0]  phase_x_r, phase_x_nxt;
  logic [PH_BITS-1:0]  phase_y_r, phase_y_nxt;
  logic [COL_BITS-1:0] in_col_r, in_col_nxt;
  logic [ROW_BITS-1:0] in_row_r, in_row_nxt;

  // Second stage: the item whose column sum is being read.
  logic                s1_valid_r;
  sum_t                s1_sample_r;
  logic [COL_BITS-1:0] s1_slot_r;
  logic                s1_first_r;
  logic                s1_emit_r;
  idx_t                s1_col_r;
  idx_t                s1_row_r;
  logic                s1_fend_r;

  // Last write to the RAM, for a read that overlapped it.
  logic                fwd_valid_r;
  logic [COL_BITS-1:0] fwd_addr_r;
  sum_t                fwd_data_r;

  // Output register.
  logic out_valid_r;
  sum_t out_sum_r;
  idx_t out_col_r2;
  idx_t out_row_r2;
  logic out_fend_r;

  logic cfg_we;
  logic in_fire;
  logic out_free;
  logic s1_fire;
  logic last_col;
  logic last_row;
  logic col_done;
  logic row_done;
  logic signed [EXT_BITS-1:0] sample_ext;
  sum_t ram_rdata;
  sum_t sum_base;
  sum_t sum_new;

  // ---------------------------------------------------------------------------
  // Configuration. Writes are to be made only while the block is idle, which it
  // does not enforce; the port is always ready. Unknown indexes are ignored.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready &&
                     ((cfg_index == CFG_SCALE) || (cfg_index == CFG_OUT_WIDTH) ||
                      (cfg_index == CFG_OUT_HEIGHT));

  always_comb begin
    scale_last_nxt = scale_last_r;
    col_last_nxt   = col_last_r;
    row_last_nxt   = row_last_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE: begin
          // A zero scale counts as one; a large one saturates.
          if (cfg_wdata[SCALE_BITS-1:0] == '0) begin
            scale_last_nxt = '0;
          end else if (int'(cfg_wdata[SCALE_BITS-1:0]) > MAX_SCALE) begin
            scale_last_nxt = PH_BITS'(MAX_SCALE - 1);
          end else begin
            scale_last_nxt = PH_BITS'(cfg_wdata[SCALE_BITS-1:0] - 1'b1);
          end
        end
        CFG_OUT_WIDTH: begin
          if (cfg_wdata == '0) begin
            col_last_nxt = '0;
          end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            col_last_nxt = COL_BITS'(MAX_WIDTH - 1);
          end else begin
            col_last_nxt = COL_BITS'(cfg_wdata - 1'b1);
          end
        end
        CFG_OUT_HEIGHT: begin
          if (cfg_wdata == '0) begin
            row_last_nxt = '0;
          end else if (int'(cfg_wdata) > ROW_LIMIT) begin
            row_last_nxt = ROW_BITS'(ROW_LIMIT - 1);
          end else begin
            row_last_nxt = ROW_BITS'(cfg_wdata - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes. The second stage moves on when the output register is free or
  // when its item produces no sum; a new sample enters whenever that stage is
  // empty or moving on.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_emit_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Position inside the plane and inside the current block.
  // ---------------------------------------------------------------------------
  assign last_col = (out_col_r == col_last_r);
  assign last_row = (out_row_r == row_last_r);
  assign col_done = last_col || (phase_x_r == scale_last_r);
  assign row_done = last_row || (phase_y_r == scale_last_r);

  always_comb begin
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    phase_x_nxt = phase_x_r;
    phase_y_nxt = phase_y_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    if (cfg_we) begin
      // Any register write starts a new frame.
      out_col_nxt = '0;
      out_row_nxt = '0;
      phase_x_nxt = '0;
      phase_y_nxt = '0;
      in_col_nxt  = '0;
      in_row_nxt  = '0;
    end else if (in_fire) begin
      if (last_col) begin
        out_col_nxt = '0;
        phase_x_nxt = '0;
        in_col_nxt  = '0;
        if (last_row) begin
          out_row_nxt = '0;
          phase_y_nxt = '0;
          in_row_nxt  = '0;
        end else begin
          out_row_nxt = out_row_r + 1'b1;
          if (phase_y_r == scale_last_r) begin
            phase_y_nxt = '0;
            in_row_nxt  = in_row_r + 1'b1;
          end else begin
            phase_y_nxt = phase_y_r + 1'b1;
          end
        end
      end else begin
        out_col_nxt = out_col_r + 1'b1;
        if (phase_x_r == scale_last_r) begin
          phase_x_nxt = '0;
          in_col_nxt  = in_col_r + 1'b1;
        end else begin
          phase_x_nxt = phase_x_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_last_r <= '0;
      col_last_r   <= COL_BITS'(COL_RST);
      row_last_r   <= ROW_BITS'(ROW_RST);
      out_col_r    <= '0;
      out_row_r    <= '0;
      phase_x_r    <= '0;
      phase_y_r    <= '0;
      in_col_r     <= '0;
      in_row_r     <= '0;
    end else begin
      scale_last_r <= scale_last_nxt;
      col_last_r   <= col_last_nxt;
      row_last_r   <= row_last_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      phase_x_r    <= phase_x_nxt;
      phase_y_r    <= phase_y_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // First stage: the accepted sample issues the read of its column sum and its
  // position details are captured for the second stage.
  // ---------------------------------------------------------------------------
  assign sample_ext = EXT_BITS'($signed(in_grad_sample));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= sample_ext[SUM_BITS-1:0];
      s1_slot_r   <= in_col_r;
      s1_first_r  <= (phase_x_r == '0) && (phase_y_r == '0);
      s1_emit_r   <= col_done && row_done;
      s1_col_r    <= IDX_BITS'(in_col_r);
      s1_row_r    <= IDX_BITS'(in_row_r);
      s1_fend_r   <= last_col && last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Second stage: add and write back. The RAM returns old data when the read
  // and the write of one edge hit the same entry, so the last write is kept
  // and forwarded on an address match. It always equals the newest contents
  // of that entry, so forwarding is also right after idle cycles.
  // ---------------------------------------------------------------------------
  upsgb_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_col_sums (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_slot_r),
    .wdata (sum_new),
    .re    (in_fire),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (s1_first_r) begin
      // The first sample of a block overwrites the entry.
      sum_base = '0;
    end else if (fwd_valid_r && (fwd_addr_r == s1_slot_r)) begin
      sum_base = fwd_data_r;
    end else begin
      sum_base = ram_rdata;
    end
    sum_new = sum_base + s1_sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_fire) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_addr_r <= s1_slot_r;
      fwd_data_r <= sum_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished sum until the consumer takes the beat.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_sum_r  <= sum_new;
      out_col_r2 <= s1_col_r;
      out_row_r2 <= s1_row_r;
      out_fend_r <= s1_fend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_block_sum = out_sum_r;
  assign out_in_col    = out_col_r2;
  assign out_in_row    = out_row_r2;
  assign out_frame_end = out_fend_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // An item held in the second stage is never dropped.
  `UGBS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_fire, s1_valid_r)
  // A sample at the top-left of its block is marked to overwrite its entry.
  `UGBS_ASSERT_NEXT(a_first_mark, in_fire && (phase_x_r == '0) && (phase_y_r == '0), s1_first_r)
  // A new sum appears only after an emitting item left the second stage.
  `UGBS_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(s1_fire && s1_emit_r))

endmodule
